FILE: src/slos_pkg.sv
// shared types, constants and helpers of the segment line-of-sight checker
package slos_pkg;

   localparam int MAX_SEGMENTS = 256;
   localparam int COORD_BITS   = 10;

   localparam int ADDR_BITS  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_SEGMENTS + 1);
   localparam int SEG_BITS   = 4 * COORD_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x0;
      logic [COORD_BITS-1:0] y0;
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
   } segment_type;

   // sight line origin and direction
   typedef struct packed {
      logic [COORD_BITS-1:0]       ax;
      logic [COORD_BITS-1:0]       ay;
      logic signed [DIFF_BITS-1:0] lx;
      logic signed [DIFF_BITS-1:0] ly;
   } line_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic blocked;
   } verdict_type;

   // field center in internal units: 2*(c mod half range) + 1
   function automatic logic [COORD_BITS-1:0] to_internal(input logic [COORD_BITS-1:0] c);
      return {c[COORD_BITS-2:0], 1'b1};
   endfunction

endpackage

FILE: src/slos_ram.sv
// generic single-write, single-read ram with registered read data
module slos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/slos_cross.sv
// pipelined crossing test of the sight line against one stored segment per cycle
module slos_cross (
   input  logic                 clock,
   input  logic                 reset,
   input  slos_pkg::tag_type     tag_in,
   input  slos_pkg::segment_type seg_in,
   input  slos_pkg::line_type    line_in,
   output slos_pkg::verdict_type verdict
);

   localparam int DB = slos_pkg::DIFF_BITS;
   localparam int PB = slos_pkg::PROD_BITS;
   localparam int CB = slos_pkg::CROSS_BITS;

   // stage 1: segment direction and offset from line origin
   slos_pkg::tag_type    tag1_ff;
   logic signed [DB-1:0] wx_ff, wy_ff, dx_ff, dy_ff;
   // stage 2: partial products
   slos_pkg::tag_type    tag2_ff;
   logic signed [PB-1:0] p_wxly_ff, p_lxwy_ff, p_lxdy_ff, p_dxly_ff, p_wxdy_ff, p_dxwy_ff;
   // stage 3: cross products
   slos_pkg::tag_type    tag3_ff;
   logic signed [CB-1:0] den_ff, u_ff, t_ff;
   // stage 4: verdict
   slos_pkg::verdict_type verdict_ff;

   logic signed [DB-1:0] wx_in, wy_in, dx_in, dy_in;
   logic signed [CB-1:0] den_in, u_in, t_in;
   logic                 den_pos, den_neg, u_pos, u_neg, t_pos, t_neg;
   logic                 blocked_in;

   always_comb begin
      wx_in = $signed({1'b0, seg_in.x1}) - $signed({1'b0, seg_in.x0});
      wy_in = $signed({1'b0, seg_in.y1}) - $signed({1'b0, seg_in.y0});
      dx_in = $signed({1'b0, seg_in.x0}) - $signed({1'b0, line_in.ax});
      dy_in = $signed({1'b0, seg_in.y0}) - $signed({1'b0, line_in.ay});

      den_in = CB'(p_wxly_ff) - CB'(p_lxwy_ff);
      u_in   = CB'(p_lxdy_ff) - CB'(p_dxly_ff);
      t_in   = CB'(p_wxdy_ff) - CB'(p_dxwy_ff);

      den_neg = den_ff[CB-1];
      den_pos = !den_ff[CB-1] && (den_ff != '0);
      u_neg   = u_ff[CB-1];
      u_pos   = !u_ff[CB-1] && (u_ff != '0);
      t_neg   = t_ff[CB-1];
      t_pos   = !t_ff[CB-1] && (t_ff != '0);
      // negative denominator: same test with the interval mirrored
      blocked_in = (den_pos && u_pos && (u_ff < den_ff) && t_pos && (t_ff < den_ff)) ||
                   (den_neg && u_neg && (u_ff > den_ff) && t_neg && (t_ff > den_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff    <= '0;
         tag2_ff    <= '0;
         tag3_ff    <= '0;
         verdict_ff <= '0;
      end else begin
         tag1_ff            <= tag_in;
         tag2_ff            <= tag1_ff;
         tag3_ff            <= tag2_ff;
         verdict_ff.valid   <= tag3_ff.valid;
         verdict_ff.last    <= tag3_ff.last;
         verdict_ff.blocked <= blocked_in;
      end
      wx_ff     <= wx_in;
      wy_ff     <= wy_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      p_wxly_ff <= wx_ff * line_in.ly;
      p_lxwy_ff <= line_in.lx * wy_ff;
      p_lxdy_ff <= line_in.lx * dy_ff;
      p_dxly_ff <= dx_ff * line_in.ly;
      p_wxdy_ff <= wx_ff * dy_ff;
      p_dxwy_ff <= dx_ff * wy_ff;
      den_ff    <= den_in;
      u_ff      <= u_in;
      t_ff      <= t_in;
   end

   assign verdict = verdict_ff;

endmodule

FILE: src/segment_line_of_sight_checker.sv
// top level of the segment line-of-sight checker: segment table, walk control and results
//
// A request is taken on a rising edge with start high and busy low. req_opcode selects
// clear (empty the table), append (store req_ax/ay/bx/by as one segment) or query (test
// the sight line from (req_ax,req_ay) to (req_bx,req_by) against every stored segment;
// req_field_mode maps query endpoints to field centers first).
// Every request gives exactly one result, shown for one cycle with rsp_valid high:
// rsp_clear_view (query only), rsp_status (append refused, table full) and rsp_entries
// (segments stored after the request). The receiver cannot stall; nothing waits on it.
// Clear, append and the unused opcode answer in the cycle after the request and keep
// busy low, so one of them can be taken every cycle.
// A query raises busy while it walks the stored segments and answers once the last verdict
// leaves the pipeline; with an empty table it answers in the cycle after it is taken. Busy
// falls as the result is shown. The walk reads one segment a cycle from the segment ram into a
// four-stage crossing pipeline, so the ram read port sets the rate.
// Synchronous reset empties the table and returns to idle; table contents are not
// cleared, only the entry count.
module segment_line_of_sight_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [slos_pkg::COORD_BITS-1:0]  req_ax,
   input  logic [slos_pkg::COORD_BITS-1:0]  req_ay,
   input  logic [slos_pkg::COORD_BITS-1:0]  req_bx,
   input  logic [slos_pkg::COORD_BITS-1:0]  req_by,
   input  logic                             req_field_mode,
   output logic                             rsp_valid,
   output logic                             rsp_clear_view,
   output logic                             rsp_status,
   output logic [slos_pkg::COUNT_BITS-1:0]  rsp_entries
);

   localparam int AB = slos_pkg::ADDR_BITS;
   localparam int NB = slos_pkg::COUNT_BITS;
   localparam int CW = slos_pkg::COORD_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type             state_ff, state_in;
   logic [NB-1:0]         count_ff, count_in;
   logic [AB-1:0]         idx_ff, idx_in;
   slos_pkg::line_type    line_ff, line_in;
   logic                  blocked_ff, blocked_in;
   slos_pkg::tag_type     issue_tag_ff, issue_tag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_clear_view_ff, rsp_clear_view_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  full;
   logic                  last_issue;
   logic                  rd_en;
   logic                  wr_en;
   logic [CW-1:0]         qax, qay, qbx, qby;
   slos_pkg::opcode_type  op;
   slos_pkg::segment_type wr_seg;
   slos_pkg::segment_type rd_seg;
   slos_pkg::verdict_type verdict;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign op         = slos_pkg::opcode_type'(req_opcode);
   assign full       = (count_ff == NB'(slos_pkg::MAX_SEGMENTS));
   assign last_issue = (NB'(idx_ff) == (count_ff - NB'(1)));

   always_comb begin
      wr_seg.x0 = req_ax;
      wr_seg.y0 = req_ay;
      wr_seg.x1 = req_bx;
      wr_seg.y1 = req_by;
      qax = req_field_mode ? slos_pkg::to_internal(req_ax) : req_ax;
      qay = req_field_mode ? slos_pkg::to_internal(req_ay) : req_ay;
      qbx = req_field_mode ? slos_pkg::to_internal(req_bx) : req_bx;
      qby = req_field_mode ? slos_pkg::to_internal(req_by) : req_by;
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      idx_in            = idx_ff;
      line_in           = line_ff;
      blocked_in        = blocked_ff || (verdict.valid && verdict.blocked);
      issue_tag_in      = '0;
      rsp_valid_in      = 1'b0;
      rsp_clear_view_in = rsp_clear_view_ff;
      rsp_status_in     = rsp_status_ff;
      rd_en             = 1'b0;
      wr_en             = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_clear_view_in = 1'b0;
               rsp_status_in     = 1'b0;
               unique case (op)
                  slos_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  slos_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + NB'(1);
                     end
                  end
                  slos_pkg::OP_QUERY: begin
                     line_in.ax = qax;
                     line_in.ay = qay;
                     line_in.lx = $signed({1'b0, qbx}) - $signed({1'b0, qax});
                     line_in.ly = $signed({1'b0, qby}) - $signed({1'b0, qay});
                     if (count_ff == '0) begin
                        rsp_valid_in      = 1'b1;
                        rsp_clear_view_in = 1'b1;
                     end else begin
                        state_in   = ST_WALK;
                        idx_in     = '0;
                        blocked_in = 1'b0;
                     end
                  end
                  slos_pkg::OP_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_en              = 1'b1;
            issue_tag_in.valid = 1'b1;
            issue_tag_in.last  = last_issue;
            idx_in             = AB'(idx_ff + AB'(1));
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (verdict.valid && verdict.last) begin
               rsp_valid_in      = 1'b1;
               rsp_clear_view_in = !(blocked_ff || verdict.blocked);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_tag_ff <= issue_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff            <= idx_in;
      line_ff           <= line_in;
      blocked_ff        <= blocked_in;
      rsp_clear_view_ff <= rsp_clear_view_in;
      rsp_status_ff     <= rsp_status_in;
   end

   slos_ram #(
      .WIDTH (slos_pkg::SEG_BITS),
      .DEPTH (slos_pkg::MAX_SEGMENTS)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AB-1:0]),
      .wr_data (wr_seg),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_seg)
   );

   slos_cross u_cross (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (issue_tag_ff),
      .seg_in  (rd_seg),
      .line_in (line_ff),
      .verdict (verdict)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clear_view = rsp_clear_view_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entries    = count_ff;

   // pipeline results only come back while a walk is running
   a_verdict_in_walk: assert property (@(posedge clock) disable iff (reset)
      verdict.valid |-> (state_ff != ST_IDLE))
      else $error("crossing verdict outside a walk");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NB'(slos_pkg::MAX_SEGMENTS))
      else $error("segment count above table size");

   a_refuse_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> full)
      else $error("append refused while table not full");

   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == slos_pkg::OP_QUERY) && (count_ff == '0))
      |=> (rsp_valid_ff && rsp_clear_view_ff && !busy))
      else $error("empty table query not answered clear at once");

   a_one_result_per_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && state_in == ST_IDLE) |=> (rsp_valid_ff && !busy))
      else $error("walk ended without a result");

endmodule

FILE: verif/tb_segment_line_of_sight_checker.sv
// testbench of the segment line-of-sight checker: directed table, random sequences, predictor
`timescale 1ns / 1ps

module tb_segment_line_of_sight_checker;

   localparam int PLANNED_REQUESTS = 1750;
   localparam int CYCLE_LIMIT      = 3_000_000;
   localparam int REPORT_LIMIT     = 100;

   typedef struct packed {
      logic                            clear_view;
      logic                            status;
      logic [slos_pkg::COUNT_BITS-1:0] entries;
   } sight_result_type;

   typedef struct packed {
      slos_pkg::opcode_type            op;
      logic [slos_pkg::COORD_BITS-1:0] ax;
      logic [slos_pkg::COORD_BITS-1:0] ay;
      logic [slos_pkg::COORD_BITS-1:0] bx;
      logic [slos_pkg::COORD_BITS-1:0] by;
      logic                            field_mode;
      logic                            pinned;
      sight_result_type                want;
   } directed_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [1:0]                      req_opcode = slos_pkg::OP_NONE;
   logic [slos_pkg::COORD_BITS-1:0] req_ax = '0;
   logic [slos_pkg::COORD_BITS-1:0] req_ay = '0;
   logic [slos_pkg::COORD_BITS-1:0] req_bx = '0;
   logic [slos_pkg::COORD_BITS-1:0] req_by = '0;
   logic                            req_field_mode = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_clear_view;
   logic                            rsp_status;
   logic [slos_pkg::COUNT_BITS-1:0] rsp_entries;

   slos_pkg::segment_type obstacle_table [slos_pkg::MAX_SEGMENTS];
   int                    obstacle_count = 0;
   sight_result_type      pending_results [$];
   int                    error_count = 0;
   int                    requests_sent = 0;
   int                    idle_pct = 0;
   int                    cycle_count = 0;

   segment_line_of_sight_checker dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_ax         (req_ax),
      .req_ay         (req_ay),
      .req_bx         (req_bx),
      .req_by         (req_by),
      .req_field_mode (req_field_mode),
      .rsp_valid      (rsp_valid),
      .rsp_clear_view (rsp_clear_view),
      .rsp_status     (rsp_status),
      .rsp_entries    (rsp_entries)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int field_center(logic [slos_pkg::COORD_BITS-1:0] c);
      return 2 * (int'(c) % (1 << (slos_pkg::COORD_BITS - 1))) + 1;
   endfunction

   // strict crossing of sight line (ox,oy)->(tx,ty) with one obstacle
   function automatic bit sight_line_blocked(int ox, int oy, int tx, int ty,
         slos_pkg::segment_type s);
      int lx, ly, wx, wy, ddx, ddy, den, u, t;
      lx  = tx - ox;
      ly  = ty - oy;
      wx  = int'(s.x1) - int'(s.x0);
      wy  = int'(s.y1) - int'(s.y0);
      den = wx * ly - lx * wy;
      if (den == 0) return 1'b0;
      ddx = int'(s.x0) - ox;
      ddy = int'(s.y0) - oy;
      u   = lx * ddy - ddx * ly;
      t   = wx * ddy - ddx * wy;
      if (den < 0) begin
         den = -den;
         u   = -u;
         t   = -t;
      end
      return (u > 0) && (u < den) && (t > 0) && (t < den);
   endfunction

   function automatic sight_result_type predict_request(slos_pkg::opcode_type op,
         logic [slos_pkg::COORD_BITS-1:0] ax, logic [slos_pkg::COORD_BITS-1:0] ay,
         logic [slos_pkg::COORD_BITS-1:0] bx, logic [slos_pkg::COORD_BITS-1:0] by,
         logic fm);
      sight_result_type r;
      int ox, oy, tx, ty;
      r = '0;
      case (op)
         slos_pkg::OP_CLEAR: begin
            obstacle_count = 0;
         end
         slos_pkg::OP_APPEND: begin
            if (obstacle_count >= slos_pkg::MAX_SEGMENTS) begin
               r.status = 1'b1;
            end else begin
               obstacle_table[obstacle_count] = {ax, ay, bx, by};
               obstacle_count++;
            end
         end
         slos_pkg::OP_QUERY: begin
            ox = fm ? field_center(ax) : int'(ax);
            oy = fm ? field_center(ay) : int'(ay);
            tx = fm ? field_center(bx) : int'(bx);
            ty = fm ? field_center(by) : int'(by);
            r.clear_view = 1'b1;
            for (int i = 0; i < obstacle_count; i++) begin
               if (sight_line_blocked(ox, oy, tx, ty, obstacle_table[i])) r.clear_view = 1'b0;
            end
         end
         default: ;
      endcase
      r.entries = slos_pkg::COUNT_BITS'(obstacle_count);
      return r;
   endfunction

   // after a request goes through, the sender may drop start for a random stretch
   task automatic pause_sender();
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic send_request(slos_pkg::opcode_type op,
         logic [slos_pkg::COORD_BITS-1:0] ax, logic [slos_pkg::COORD_BITS-1:0] ay,
         logic [slos_pkg::COORD_BITS-1:0] bx, logic [slos_pkg::COORD_BITS-1:0] by,
         logic fm, bit pinned = 1'b0, sight_result_type pinned_result = '0);
      sight_result_type predicted;
      start          <= 1'b1;
      req_opcode     <= op;
      req_ax         <= ax;
      req_ay         <= ay;
      req_bx         <= bx;
      req_by         <= by;
      req_field_mode <= fm;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_request(op, ax, ay, bx, by, fm);
      pending_results.push_back(pinned ? pinned_result : predicted);
      if (op != slos_pkg::OP_NONE) requests_sent++;
      pause_sender();
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      sight_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: result with no request waiting: clear_view %b status %b entries %0d",
                        $time, rsp_clear_view, rsp_status, rsp_entries);
         end else begin
            want = pending_results.pop_front();
            if (rsp_clear_view !== want.clear_view) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: clear_view expected %b actual %b",
                           $time, want.clear_view, rsp_clear_view);
            end
            if (rsp_status !== want.status) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: status expected %b actual %b", $time, want.status, rsp_status);
            end
            if (rsp_entries !== want.entries) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: entries expected %0d actual %0d",
                           $time, want.entries, rsp_entries);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_segment_line_of_sight_checker failed");
         $finish;
      end
   end

   initial begin
      directed_row_type                directed_rows [16];
      logic [slos_pkg::COORD_BITS-1:0] ax, ay, bx, by, dx, dy;
      logic                            fm;
      slos_pkg::segment_type           s;
      int                              seq_index, n_append, n_query, kind, new_pct;

      directed_rows = '{
         // empty table never blocks
         '{slos_pkg::OP_QUERY,  10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0,
           1'b1, '{1'b1, 1'b0, 9'd0}},
         '{slos_pkg::OP_NONE,   10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1,
           1'b1, '{1'b0, 1'b0, 9'd0}},
         '{slos_pkg::OP_APPEND, 10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0,
           1'b1, '{1'b0, 1'b0, 9'd1}},
         '{slos_pkg::OP_QUERY,  10'd0,    10'd1023, 10'd1023, 10'd0,    1'b0,
           1'b0, '0},
         // parallel, collinear and zero-length sight lines
         '{slos_pkg::OP_QUERY,  10'd1,    10'd0,    10'd1023, 10'd1022, 1'b0,
           1'b0, '0},
         '{slos_pkg::OP_QUERY,  10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0,
           1'b0, '0},
         '{slos_pkg::OP_QUERY,  10'd5,    10'd5,    10'd5,    10'd5,    1'b0,
           1'b0, '0},
         '{slos_pkg::OP_APPEND, 10'd7,    10'd7,    10'd7,    10'd7,    1'b1,
           1'b1, '{1'b0, 1'b0, 9'd2}},
         '{slos_pkg::OP_QUERY,  10'd0,    10'd1023, 10'd1023, 10'd0,    1'b1,
           1'b0, '0},
         '{slos_pkg::OP_QUERY,  10'd512,  10'd0,    10'd0,    10'd512,  1'b1,
           1'b0, '0},
         // line ends exactly on the stored diagonal
         '{slos_pkg::OP_QUERY,  10'd0,    10'd1022, 10'd511,  10'd511,  1'b0,
           1'b0, '0},
         '{slos_pkg::OP_APPEND, 10'd1023, 10'd0,    10'd0,    10'd1023, 1'b1,
           1'b1, '{1'b0, 1'b0, 9'd3}},
         '{slos_pkg::OP_QUERY,  10'd0,    10'd512,  10'd1023, 10'd512,  1'b0,
           1'b0, '0},
         '{slos_pkg::OP_NONE,   10'd0,    10'd0,    10'd0,    10'd0,    1'b0,
           1'b1, '{1'b0, 1'b0, 9'd3}},
         '{slos_pkg::OP_CLEAR,  10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1,
           1'b1, '{1'b0, 1'b0, 9'd0}},
         '{slos_pkg::OP_QUERY,  10'd0,    10'd1023, 10'd1023, 10'd0,    1'b0,
           1'b1, '{1'b1, 1'b0, 9'd0}}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 20;
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].ax, directed_rows[i].ay,
                      directed_rows[i].bx, directed_rows[i].by, directed_rows[i].field_mode,
                      directed_rows[i].pinned, directed_rows[i].want);
      drain_results();

      seq_index = 0;
      while (requests_sent < PLANNED_REQUESTS) begin
         if (requests_sent < PLANNED_REQUESTS / 3) new_pct = 20;
         else if (requests_sent < 2 * PLANNED_REQUESTS / 3) new_pct = 48;
         else new_pct = 0;
         if (new_pct != idle_pct) begin
            drain_results();
            idle_pct = new_pct;
         end

         if (seq_index == 0 || $urandom_range(9) != 0)
            send_request(slos_pkg::OP_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom),
                         10'($urandom), 1'($urandom));

         // now and then fill the table up to or past full
         if (seq_index % 20 == 0 || $urandom_range(19) == 0)
            n_append = slos_pkg::MAX_SEGMENTS + $urandom_range(3);
         else
            n_append = $urandom_range(24);
         for (int i = 0; i < n_append; i++) begin
            if ($urandom_range(29) == 0)
               send_request(slos_pkg::OP_NONE, 10'($urandom), 10'($urandom), 10'($urandom),
                            10'($urandom), 1'($urandom));
            ax = 10'($urandom);
            ay = 10'($urandom);
            if ($urandom_range(1) == 0) begin
               bx = 10'($urandom);
               by = 10'($urandom);
            end else begin
               bx = ax + 10'($urandom_range(128)) - 10'd64;
               by = ay + 10'($urandom_range(128)) - 10'd64;
            end
            send_request(slos_pkg::OP_APPEND, ax, ay, bx, by, 1'($urandom));
         end

         n_query = 1 + $urandom_range(7);
         for (int i = 0; i < n_query; i++) begin
            kind = $urandom_range(9);
            ax = 10'($urandom);
            ay = 10'($urandom);
            bx = 10'($urandom);
            by = 10'($urandom);
            fm = ($urandom_range(3) == 0);
            if (kind >= 6 && obstacle_count > 0) begin
               s  = obstacle_table[$urandom_range(obstacle_count - 1)];
               fm = 1'b0;
               if (kind < 8) begin
                  // shifted copy of a stored obstacle: parallel or collinear
                  dx = 10'($urandom_range(2));
                  dy = 10'($urandom_range(2));
                  ax = s.x0 + dx;
                  ay = s.y0 + dy;
                  bx = s.x1 + dx;
                  by = s.y1 + dy;
               end else begin
                  // line ends on an obstacle endpoint
                  bx = s.x0;
                  by = s.y0;
               end
            end
            send_request(slos_pkg::OP_QUERY, ax, ay, bx, by, fm);
         end
         seq_index++;
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_segment_line_of_sight_checker passed");
      end else begin
         $display("tb_segment_line_of_sight_checker failed");
      end
      $finish;
   end

endmodule
